// File: design/stt_pkg.sv
package stt_pkg;

   localparam int KEYWORD_COUNT = 10;
   localparam int RES_SLOTS     = 4;
   localparam int CNT_W         = $clog2(RES_SLOTS + 1);
   localparam int IDX_W         = $clog2(RES_SLOTS);

   localparam logic [5:0] TOK_NUMBER     = 6'd0;
   localparam logic [5:0] TOK_PLUS       = 6'd1;
   localparam logic [5:0] TOK_MINUS      = 6'd2;
   localparam logic [5:0] TOK_STAR       = 6'd3;
   localparam logic [5:0] TOK_SLASH      = 6'd4;
   localparam logic [5:0] TOK_LPAREN     = 6'd5;
   localparam logic [5:0] TOK_RPAREN     = 6'd6;
   localparam logic [5:0] TOK_EOF        = 6'd7;
   localparam logic [5:0] TOK_SEMI       = 6'd8;
   localparam logic [5:0] TOK_ERROR      = 6'd9;
   localparam logic [5:0] TOK_CHAR       = 6'd10;
   localparam logic [5:0] TOK_STRING     = 6'd11;
   localparam logic [5:0] TOK_IDENT      = 6'd12;
   localparam logic [5:0] TOK_EQ         = 6'd13;
   localparam logic [5:0] TOK_EQ_EQ      = 6'd14;
   localparam logic [5:0] TOK_BANG       = 6'd15;
   localparam logic [5:0] TOK_BANG_EQ    = 6'd16;
   localparam logic [5:0] TOK_LESS       = 6'd17;
   localparam logic [5:0] TOK_LESS_EQ    = 6'd18;
   localparam logic [5:0] TOK_SHL        = 6'd19;
   localparam logic [5:0] TOK_GREATER    = 6'd20;
   localparam logic [5:0] TOK_GREATER_EQ = 6'd21;
   localparam logic [5:0] TOK_SHR        = 6'd22;
   localparam logic [5:0] TOK_AMP        = 6'd23;
   localparam logic [5:0] TOK_AND        = 6'd24;
   localparam logic [5:0] TOK_BITOR      = 6'd25;
   localparam logic [5:0] TOK_OR         = 6'd26;
   localparam logic [5:0] TOK_PERCENT    = 6'd27;
   localparam logic [5:0] TOK_CARET      = 6'd28;
   localparam logic [5:0] TOK_TILDE      = 6'd29;
   localparam logic [5:0] TOK_LSQUARE    = 6'd30;
   localparam logic [5:0] TOK_RSQUARE    = 6'd31;
   localparam logic [5:0] TOK_LCURLY     = 6'd32;
   localparam logic [5:0] TOK_RCURLY     = 6'd33;
   localparam logic [5:0] TOK_COMMA      = 6'd34;
   localparam logic [5:0] TOK_DOT        = 6'd35;
   localparam logic [5:0] TOK_COLON      = 6'd36;

   localparam logic [7:0] CH_APOS      = 8'h27;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_DOT       = 8'h2E;

   typedef enum logic [3:0] {
      MODE_IDLE      = 4'd0,
      MODE_NUM_INT   = 4'd1,
      MODE_NUM_FRAC  = 4'd2,
      MODE_CHR_BODY  = 4'd3,
      MODE_CHR_ESC   = 4'd4,
      MODE_CHR_CLOSE = 4'd5,
      MODE_STR       = 4'd6,
      MODE_STR_ESC   = 4'd7,
      MODE_IDENT     = 4'd8,
      MODE_OP        = 4'd9
   } mode_type;

   typedef struct packed {
      logic       kind;
      logic [5:0] tok;
      logic [7:0] value;
      logic       last;
   } rec_type;

   typedef logic [KEYWORD_COUNT-1:0] cand_type;
   typedef logic [0:7][7:0] kw_text_type;

   localparam kw_text_type KW_TEXT [KEYWORD_COUNT] = '{
      {"true", 32'd0}, {"false", 24'd0}, {"return", 16'd0}, {"if", 48'd0},
      {"then", 32'd0}, {"else", 32'd0}, {"while", 24'd0}, {"do", 48'd0},
      {"fn", 48'd0}, {"struct", 16'd0}
   };
   localparam logic [2:0] KW_LEN [KEYWORD_COUNT] = '{
      3'd4, 3'd5, 3'd6, 3'd2, 3'd4, 3'd4, 3'd5, 3'd2, 3'd2, 3'd6
   };
   localparam logic [5:0] KW_CODE [KEYWORD_COUNT] = '{
      6'd37, 6'd38, 6'd41, 6'd44, 6'd45, 6'd46, 6'd47, 6'd48, 6'd49, 6'd50
   };

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic ident_start(input logic [7:0] c);
      return is_alpha(c) || c == "_";
   endfunction

   function automatic logic ident_char(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == "_";
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         "n": r = 8'd10;
         "t": r = 8'd9;
         "r": r = 8'd13;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic logic [5:0] one_char_type(input logic [7:0] c);
      logic [5:0] t;
      case (c)
         "+": t = TOK_PLUS;
         "-": t = TOK_MINUS;
         "*": t = TOK_STAR;
         "/": t = TOK_SLASH;
         "%": t = TOK_PERCENT;
         "^": t = TOK_CARET;
         "~": t = TOK_TILDE;
         "(": t = TOK_LPAREN;
         ")": t = TOK_RPAREN;
         "[": t = TOK_LSQUARE;
         "]": t = TOK_RSQUARE;
         "{": t = TOK_LCURLY;
         "}": t = TOK_RCURLY;
         ",": t = TOK_COMMA;
         ".": t = TOK_DOT;
         ":": t = TOK_COLON;
         ";": t = TOK_SEMI;
         "=": t = TOK_EQ;
         "!": t = TOK_BANG;
         "<": t = TOK_LESS;
         ">": t = TOK_GREATER;
         "&": t = TOK_AMP;
         "|": t = TOK_BITOR;
         default: t = TOK_ERROR;
      endcase
      return t;
   endfunction

   function automatic logic [5:0] extend_op(input logic [5:0] t, input logic [7:0] c);
      logic [5:0] r;
      r = t;
      if (t == TOK_EQ && c == "=") r = TOK_EQ_EQ;
      if (t == TOK_BANG && c == "=") r = TOK_BANG_EQ;
      if (t == TOK_LESS && c == "=") r = TOK_LESS_EQ;
      if (t == TOK_LESS && c == "<") r = TOK_SHL;
      if (t == TOK_GREATER && c == "=") r = TOK_GREATER_EQ;
      if (t == TOK_GREATER && c == ">") r = TOK_SHR;
      if (t == TOK_AMP && c == "&") r = TOK_AND;
      if (t == TOK_BITOR && c == "|") r = TOK_OR;
      return r;
   endfunction

   function automatic logic can_extend(input logic [5:0] t);
      return t == TOK_EQ || t == TOK_BANG || t == TOK_LESS || t == TOK_GREATER
         || t == TOK_AMP || t == TOK_BITOR;
   endfunction

   // drop keywords too short for pos or whose char at pos isn't c
   function automatic cand_type kw_filter(input cand_type cand, input logic [2:0] pos,
                                          input logic [7:0] c);
      cand_type r;
      r = cand;
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         if (pos >= KW_LEN[i] || KW_TEXT[i][pos] != c) r[i] = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [5:0] kw_type(input cand_type cand, input logic [2:0] len);
      logic [5:0] r;
      r = TOK_IDENT;
      for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
         if (cand[i] && len == KW_LEN[i]) r = KW_CODE[i];
      end
      return r;
   endfunction

   function automatic rec_type mk_byte(input logic [7:0] c);
      return '{kind: 1'b0, tok: 6'd0, value: c, last: 1'b0};
   endfunction

   function automatic rec_type mk_end(input logic [5:0] t);
      return '{kind: 1'b1, tok: t, value: 8'd0, last: 1'b0};
   endfunction

endpackage

// File: design/source_text_tokenizer.sv
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | req_src_byte, req_end_of_input
// rsp     | out       | rsp_valid/rsp_ready | rsp_record_kind, rsp_token_type,
//         |           |                     | rsp_value_byte, rsp_last_in_run
//
// An item is decoded in the cycle it is accepted; its zero to three records land
// in a small output buffer and leave one per cycle while rsp_ready is high,
// starting the next cycle. A new item is taken when the buffer is empty or its
// last record leaves that cycle, so throughput is one item per cycle with rsp_ready
// high for items yielding at most one record; else the next item waits for the buffer.
// Synchronous reset returns the lexer to idle and empties the buffer.
// Holding rsp_ready low stalls req_ready once a record is waiting.
module source_text_tokenizer
   import stt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_src_byte,
   input  logic       req_end_of_input,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_record_kind,
   output logic [5:0] rsp_token_type,
   output logic [7:0] rsp_value_byte,
   output logic       rsp_last_in_run
);

   mode_type   mode_ff, mode_in;
   logic [5:0] pend_ff, pend_in;
   logic [7:0] lit_ff, lit_in;
   cand_type   cand_ff, cand_in;
   logic [2:0] len_ff, len_in;

   rec_type    slot_ff [RES_SLOTS];
   rec_type    slot_in [RES_SLOTS];
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   rec_type    res [RES_SLOTS];
   logic [CNT_W-1:0] n;
   logic [7:0] c;
   logic       eof;
   logic       start;
   logic [5:0] t;
   logic       accept;
   logic       pop;

   assign rsp_valid       = cnt_ff != '0;
   assign pop             = rsp_valid && rsp_ready;
   assign req_ready       = (cnt_ff == '0) || (cnt_ff == CNT_W'(1) && rsp_ready);
   assign accept          = req_valid && req_ready;
   assign rsp_record_kind = slot_ff[0].kind;
   assign rsp_token_type  = slot_ff[0].tok;
   assign rsp_value_byte  = slot_ff[0].value;
   assign rsp_last_in_run = slot_ff[0].last;

   always_comb begin
      c       = req_src_byte;
      eof     = req_end_of_input || (req_src_byte == 8'd0);
      n       = '0;
      start   = 1'b0;
      t       = TOK_ERROR;
      mode_in = mode_ff;
      pend_in = pend_ff;
      lit_in  = lit_ff;
      cand_in = cand_ff;
      len_in  = len_ff;
      for (int i = 0; i < RES_SLOTS; i++) res[i] = mk_end(TOK_ERROR);

      case (mode_ff)
         MODE_NUM_INT: begin
            if (!eof && is_digit(c)) begin
               res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
            end else if (!eof && c == CH_DOT) begin
               res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
               mode_in = MODE_NUM_FRAC;
            end else begin
               res[n[IDX_W-1:0]] = mk_end(TOK_NUMBER); n = n + CNT_W'(1);
               start = 1'b1;
            end
         end
         MODE_NUM_FRAC: begin
            if (!eof && is_digit(c)) begin
               res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
            end else begin
               res[n[IDX_W-1:0]] = mk_end(TOK_NUMBER); n = n + CNT_W'(1);
               start = 1'b1;
            end
         end
         MODE_CHR_BODY: begin
            if (eof) begin
               res[n[IDX_W-1:0]] = mk_end(TOK_ERROR); n = n + CNT_W'(1);
               start = 1'b1;
            end else if (c == CH_BACKSLASH) begin
               mode_in = MODE_CHR_ESC;
            end else begin
               lit_in  = c;
               mode_in = MODE_CHR_CLOSE;
            end
         end
         MODE_CHR_ESC: begin
            if (eof) begin
               res[n[IDX_W-1:0]] = mk_end(TOK_ERROR); n = n + CNT_W'(1);
               start = 1'b1;
            end else begin
               lit_in  = unescape(c);
               mode_in = MODE_CHR_CLOSE;
            end
         end
         MODE_CHR_CLOSE: begin
            if (!eof && c == CH_APOS) begin
               res[n[IDX_W-1:0]] = mk_byte(lit_ff); n = n + CNT_W'(1);
               res[n[IDX_W-1:0]] = mk_end(TOK_CHAR); n = n + CNT_W'(1);
               mode_in = MODE_IDLE;
            end else begin
               res[n[IDX_W-1:0]] = mk_end(TOK_ERROR); n = n + CNT_W'(1);
               start = 1'b1;
            end
         end
         MODE_STR: begin
            if (eof) begin
               res[n[IDX_W-1:0]] = mk_end(TOK_ERROR); n = n + CNT_W'(1);
               start = 1'b1;
            end else if (c == CH_QUOTE) begin
               res[n[IDX_W-1:0]] = mk_end(TOK_STRING); n = n + CNT_W'(1);
               mode_in = MODE_IDLE;
            end else if (c == CH_BACKSLASH) begin
               mode_in = MODE_STR_ESC;
            end else begin
               res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
            end
         end
         MODE_STR_ESC: begin
            if (eof) begin
               res[n[IDX_W-1:0]] = mk_end(TOK_ERROR); n = n + CNT_W'(1);
               start = 1'b1;
            end else begin
               res[n[IDX_W-1:0]] = mk_byte(unescape(c)); n = n + CNT_W'(1);
               mode_in = MODE_STR;
            end
         end
         MODE_IDENT: begin
            if (!eof && ident_char(c)) begin
               cand_in = kw_filter(cand_ff, len_ff, c);
               if (len_ff != 3'd7) len_in = len_ff + 3'd1;
               res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
            end else begin
               res[n[IDX_W-1:0]] = mk_end(kw_type(cand_ff, len_ff)); n = n + CNT_W'(1);
               start = 1'b1;
            end
         end
         MODE_OP: begin
            t = eof ? pend_ff : extend_op(pend_ff, c);
            if (t != pend_ff) begin
               res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
               res[n[IDX_W-1:0]] = mk_end(t); n = n + CNT_W'(1);
               mode_in = MODE_IDLE;
            end else begin
               res[n[IDX_W-1:0]] = mk_end(pend_ff); n = n + CNT_W'(1);
               start = 1'b1;
            end
         end
         default: begin
            start = 1'b1;
         end
      endcase

      if (start) begin
         mode_in = MODE_IDLE;
         if (eof) begin
            res[n[IDX_W-1:0]] = mk_end(TOK_EOF); n = n + CNT_W'(1);
         end else if (is_space(c)) begin
            mode_in = MODE_IDLE;
         end else if (is_digit(c)) begin
            res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
            mode_in = MODE_NUM_INT;
         end else if (c == CH_APOS) begin
            mode_in = MODE_CHR_BODY;
         end else if (c == CH_QUOTE) begin
            mode_in = MODE_STR;
         end else if (ident_start(c)) begin
            cand_in = kw_filter('1, 3'd0, c);
            len_in  = 3'd1;
            res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
            mode_in = MODE_IDENT;
         end else begin
            t = one_char_type(c);
            if (t == TOK_ERROR) begin
               res[n[IDX_W-1:0]] = mk_end(TOK_ERROR); n = n + CNT_W'(1);
            end else begin
               res[n[IDX_W-1:0]] = mk_byte(c); n = n + CNT_W'(1);
               if (can_extend(t)) begin
                  pend_in = t;
                  mode_in = MODE_OP;
               end else begin
                  res[n[IDX_W-1:0]] = mk_end(t); n = n + CNT_W'(1);
               end
            end
         end
      end

      for (int i = 0; i < RES_SLOTS; i++) res[i].last = (CNT_W'(i + 1) == n);
   end

   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < RES_SLOTS; i++) slot_in[i] = slot_ff[i];
      if (accept) begin
         for (int i = 0; i < RES_SLOTS; i++) slot_in[i] = res[i];
         cnt_in = n;
      end else if (pop) begin
         for (int i = 0; i < RES_SLOTS - 1; i++) slot_in[i] = slot_ff[i + 1];
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < RES_SLOTS; i++) slot_ff[i] <= slot_in[i];
      if (reset) begin
         cnt_ff  <= '0;
         mode_ff <= MODE_IDLE;
         pend_ff <= 6'd0;
         cand_ff <= '1;
         len_ff  <= 3'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (accept) begin
            mode_ff <= mode_in;
            pend_ff <= pend_in;
            cand_ff <= cand_in;
            len_ff  <= len_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lit_ff <= 8'd0;
      end else if (accept) begin
         lit_ff <= lit_in;
      end
   end

   a_accept_only_when_draining: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (cnt_ff <= CNT_W'(1)))
      else $error("item accepted while buffer still holds records");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(RES_SLOTS - 1))
      else $error("record buffer overfilled");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_in_run && !(req_valid && req_ready))
      |=> (cnt_ff == '0))
      else $error("records left after last record of an item");

   a_ident_len: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_IDENT) |-> (len_ff != 3'd0))
      else $error("identifier mode with zero length");

endmodule

// File: verif/source_text_tokenizer_test.sv
module source_text_tokenizer_test
   import stt_pkg::*;
();

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int PHASE_ITEMS    = 58;

   localparam logic [5:0] TOK_TRUE   = 6'd37;
   localparam logic [5:0] TOK_FALSE  = 6'd38;
   localparam logic [5:0] TOK_RETURN = 6'd41;
   localparam logic [5:0] TOK_IF     = 6'd44;
   localparam logic [5:0] TOK_THEN   = 6'd45;
   localparam logic [5:0] TOK_ELSE   = 6'd46;
   localparam logic [5:0] TOK_WHILE  = 6'd47;
   localparam logic [5:0] TOK_DO     = 6'd48;
   localparam logic [5:0] TOK_FN     = 6'd49;
   localparam logic [5:0] TOK_STRUCT = 6'd50;

   localparam logic [5:0] KW_TOK [KEYWORD_COUNT] = '{
      TOK_TRUE, TOK_FALSE, TOK_RETURN, TOK_IF, TOK_THEN,
      TOK_ELSE, TOK_WHILE, TOK_DO, TOK_FN, TOK_STRUCT
   };
   string kw_word [KEYWORD_COUNT] = '{
      "true", "false", "return", "if", "then", "else", "while", "do", "fn", "struct"
   };

   typedef struct {
      logic [7:0] ch;
      logic       eoi;
      int         phase;
      bit         drain;
   } src_item_type;

   int send_idle_pct [3] = '{36, 60, 0};
   int recv_idle_pct [3] = '{60, 36, 0};

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_src_byte = 8'd0;
   logic       req_end_of_input = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_record_kind;
   logic [5:0] rsp_token_type;
   logic [7:0] rsp_value_byte;
   logic       rsp_last_in_run;

   src_item_type src_items [$];
   rec_type   token_records_due [$];
   rec_type   step_recs [$];

   // lexer state
   mode_type   lx_mode = MODE_IDLE;
   logic [5:0] held_op = 6'd0;
   logic [7:0] held_char = 8'd0;
   cand_type   kw_live = '1;
   logic [2:0] word_len = 3'd0;

   int gen_phase = 0;
   bit gen_hold = 0;
   int cur_phase = 0;
   src_item_type next_item;
   bit send_now;
   int idle_cycles = 0;
   int mismatches = 0;
   int bytes_lexed = 0;
   int records_checked = 0;
   int token_ends = 0;
   int error_ends = 0;

   source_text_tokenizer DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_src_byte     (req_src_byte),
      .req_end_of_input (req_end_of_input),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_record_kind  (rsp_record_kind),
      .rsp_token_type   (rsp_token_type),
      .rsp_value_byte   (rsp_value_byte),
      .rsp_last_in_run  (rsp_last_in_run)
   );

   always #10 clock = ~clock;

   function automatic logic is_num(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
   endfunction

   function automatic logic [7:0] escaped(input logic [7:0] c);
      if (c == "n") return 8'd10;
      if (c == "t") return 8'd9;
      if (c == "r") return 8'd13;
      return c;
   endfunction

   function automatic void put_rec(input logic k, input logic [5:0] t, input logic [7:0] v);
      step_recs.push_back('{kind: k, tok: t, value: v, last: 1'b0});
   endfunction

   function automatic void word_add(input logic [7:0] c);
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
         if (word_len >= kw_word[i].len() || kw_word[i][word_len] != c) kw_live[i] = 1'b0;
      end
      if (word_len != 3'd7) word_len++;
   endfunction

   function automatic void open_token(input logic [7:0] c, input logic eoi);
      logic [5:0] op;
      lx_mode = MODE_IDLE;
      if (eoi) begin
         put_rec(1'b1, TOK_EOF, 8'd0);
      end else if (!(c == " " || (c >= 8'd9 && c <= 8'd13))) begin
         if (is_num(c)) begin
            put_rec(1'b0, 6'd0, c);
            lx_mode = MODE_NUM_INT;
         end else if (c == CH_APOS) begin
            lx_mode = MODE_CHR_BODY;
         end else if (c == CH_QUOTE) begin
            lx_mode = MODE_STR;
         end else if (is_letter(c)) begin
            word_len = 3'd0;
            kw_live = '1;
            word_add(c);
            put_rec(1'b0, 6'd0, c);
            lx_mode = MODE_IDENT;
         end else begin
            case (c)
               "+": op = TOK_PLUS;     "-": op = TOK_MINUS;    "*": op = TOK_STAR;
               "/": op = TOK_SLASH;    "%": op = TOK_PERCENT;  "^": op = TOK_CARET;
               "~": op = TOK_TILDE;    "(": op = TOK_LPAREN;   ")": op = TOK_RPAREN;
               "[": op = TOK_LSQUARE;  "]": op = TOK_RSQUARE;  "{": op = TOK_LCURLY;
               "}": op = TOK_RCURLY;   ",": op = TOK_COMMA;    ".": op = TOK_DOT;
               ":": op = TOK_COLON;    ";": op = TOK_SEMI;     "=": op = TOK_EQ;
               "!": op = TOK_BANG;     "<": op = TOK_LESS;     ">": op = TOK_GREATER;
               "&": op = TOK_AMP;      "|": op = TOK_BITOR;
               default: op = TOK_ERROR;
            endcase
            if (op == TOK_ERROR) begin
               put_rec(1'b1, TOK_ERROR, 8'd0);
            end else begin
               put_rec(1'b0, 6'd0, c);
               if (op == TOK_EQ || op == TOK_BANG || op == TOK_LESS || op == TOK_GREATER
                   || op == TOK_AMP || op == TOK_BITOR) begin
                  held_op = op;
                  lx_mode = MODE_OP;
               end else begin
                  put_rec(1'b1, op, 8'd0);
               end
            end
         end
      end
   endfunction

   function automatic void abandon(input logic [7:0] c, input logic eoi);
      put_rec(1'b1, TOK_ERROR, 8'd0);
      open_token(c, eoi);
   endfunction

   function automatic void lex_step(input logic [7:0] c, input logic eoi_in);
      logic eoi;
      logic [5:0] t;
      eoi = eoi_in || c == 8'd0;
      step_recs.delete();
      case (lx_mode)
         MODE_NUM_INT: begin
            if (!eoi && is_num(c)) begin
               put_rec(1'b0, 6'd0, c);
            end else if (!eoi && c == CH_DOT) begin
               put_rec(1'b0, 6'd0, c);
               lx_mode = MODE_NUM_FRAC;
            end else begin
               put_rec(1'b1, TOK_NUMBER, 8'd0);
               open_token(c, eoi);
            end
         end
         MODE_NUM_FRAC: begin
            if (!eoi && is_num(c)) begin
               put_rec(1'b0, 6'd0, c);
            end else begin
               put_rec(1'b1, TOK_NUMBER, 8'd0);
               open_token(c, eoi);
            end
         end
         MODE_CHR_BODY: begin
            if (eoi) abandon(c, eoi);
            else if (c == CH_BACKSLASH) lx_mode = MODE_CHR_ESC;
            else begin
               held_char = c;
               lx_mode = MODE_CHR_CLOSE;
            end
         end
         MODE_CHR_ESC: begin
            if (eoi) abandon(c, eoi);
            else begin
               held_char = escaped(c);
               lx_mode = MODE_CHR_CLOSE;
            end
         end
         MODE_CHR_CLOSE: begin
            if (!eoi && c == CH_APOS) begin
               put_rec(1'b0, 6'd0, held_char);
               put_rec(1'b1, TOK_CHAR, 8'd0);
               lx_mode = MODE_IDLE;
            end else begin
               abandon(c, eoi);
            end
         end
         MODE_STR: begin
            if (eoi) abandon(c, eoi);
            else if (c == CH_QUOTE) begin
               put_rec(1'b1, TOK_STRING, 8'd0);
               lx_mode = MODE_IDLE;
            end else if (c == CH_BACKSLASH) lx_mode = MODE_STR_ESC;
            else put_rec(1'b0, 6'd0, c);
         end
         MODE_STR_ESC: begin
            if (eoi) abandon(c, eoi);
            else begin
               put_rec(1'b0, 6'd0, escaped(c));
               lx_mode = MODE_STR;
            end
         end
         MODE_IDENT: begin
            if (!eoi && (is_letter(c) || is_num(c))) begin
               word_add(c);
               put_rec(1'b0, 6'd0, c);
            end else begin
               t = TOK_IDENT;
               for (int i = KEYWORD_COUNT - 1; i >= 0; i--) begin
                  if (kw_live[i] && word_len == kw_word[i].len()) t = KW_TOK[i];
               end
               put_rec(1'b1, t, 8'd0);
               open_token(c, eoi);
            end
         end
         MODE_OP: begin
            t = held_op;
            if (!eoi) begin
               case (held_op)
                  TOK_EQ:      if (c == "=") t = TOK_EQ_EQ;
                  TOK_BANG:    if (c == "=") t = TOK_BANG_EQ;
                  TOK_LESS:    if (c == "=") t = TOK_LESS_EQ; else if (c == "<") t = TOK_SHL;
                  TOK_GREATER: if (c == "=") t = TOK_GREATER_EQ; else if (c == ">") t = TOK_SHR;
                  TOK_AMP:     if (c == "&") t = TOK_AND;
                  TOK_BITOR:   if (c == "|") t = TOK_OR;
                  default: ;
               endcase
            end
            if (t != held_op) begin
               put_rec(1'b0, 6'd0, c);
               put_rec(1'b1, t, 8'd0);
               lx_mode = MODE_IDLE;
            end else begin
               put_rec(1'b1, held_op, 8'd0);
               open_token(c, eoi);
            end
         end
         default: open_token(c, eoi);
      endcase
      if (step_recs.size() != 0) step_recs[step_recs.size() - 1].last = 1'b1;
      foreach (step_recs[i]) token_records_due.push_back(step_recs[i]);
   endfunction

   task automatic flag_mismatch(input string what);
      mismatches++;
      $display("%0t: mismatch: %s", $time, what);
   endtask

   task automatic push_byte(input logic [7:0] c, input logic eoi);
      src_items.push_back('{c, eoi, gen_phase, gen_hold});
      gen_hold = 0;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0);
   endtask

   task automatic add_random_token();
      string ops1;
      string ops2;
      string word_chars;
      string esc_chars;
      int pick;
      int n;
      int k;
      ops1 = "+-*/%^~()[]{},.:;=!<>&|";
      ops2 = "==!=<=<<>=>>&&||";
      word_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      esc_chars = "ntr\\'\"qz";
      pick = $urandom_range(99);
      if (pick < 15) begin
         n = $urandom_range(1, 4);
         repeat (n) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
         if ($urandom_range(1)) begin
            push_byte(CH_DOT, 1'b0);
            n = $urandom_range(0, 3);
            repeat (n) push_byte(8'("0" + $urandom_range(0, 9)), 1'b0);
         end
      end else if (pick < 25) begin
         push_byte(CH_APOS, 1'b0);
         if ($urandom_range(9) < 4) begin
            push_byte(CH_BACKSLASH, 1'b0);
            push_byte(esc_chars[$urandom_range(esc_chars.len() - 1)], 1'b0);
         end else begin
            push_byte(8'($urandom_range(1, 255)), 1'b0);
         end
         if ($urandom_range(99) < 85) push_byte(CH_APOS, 1'b0);
      end else if (pick < 37) begin
         push_byte(CH_QUOTE, 1'b0);
         n = $urandom_range(0, 6);
         repeat (n) begin
            k = $urandom_range(99);
            if (k < 15) begin
               push_byte(CH_BACKSLASH, 1'b0);
               push_byte(esc_chars[$urandom_range(esc_chars.len() - 1)], 1'b0);
            end else if (k < 25) begin
               push_byte(8'($urandom_range(128, 255)), 1'b0);
            end else begin
               push_byte(8'($urandom_range(32, 126)), 1'b0);
            end
         end
         if ($urandom_range(99) < 90) push_byte(CH_QUOTE, 1'b0);
      end else if (pick < 57) begin
         if ($urandom_range(1)) begin
            k = $urandom_range(KEYWORD_COUNT - 1);
            n = $urandom_range(9);
            if (n < 2) begin
               for (int i = 0; i < kw_word[k].len() - 1; i++) push_byte(kw_word[k][i], 1'b0);
            end else begin
               push_text(kw_word[k]);
               if (n < 4) push_byte(word_chars[$urandom_range(word_chars.len() - 1)], 1'b0);
            end
         end else begin
            push_byte(word_chars[$urandom_range(52)], 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) push_byte(word_chars[$urandom_range(word_chars.len() - 1)], 1'b0);
         end
      end else if (pick < 77) begin
         if ($urandom_range(1)) begin
            push_byte(ops1[$urandom_range(ops1.len() - 1)], 1'b0);
         end else begin
            k = 2 * $urandom_range(7);
            push_byte(ops2[k], 1'b0);
            push_byte(ops2[k + 1], 1'b0);
         end
      end else if (pick < 85) begin
         n = $urandom_range(1, 3);
         repeat (n) begin
            k = $urandom_range(9, 14);
            push_byte((k == 14) ? 8'd32 : 8'(k), 1'b0);
         end
      end else if (pick < 95) begin
         push_byte(8'($urandom_range(1, 255)), 1'b0);
      end else if ($urandom_range(1)) begin
         push_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         push_byte(8'd0, 1'b0);
      end
      if ($urandom_range(99) < 40) push_byte(" ", 1'b0);
   endtask

   // source byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            lex_step(req_src_byte, req_end_of_input);
            bytes_lexed++;
         end
         if (!req_valid || req_ready) begin
            send_now = 0;
            if (src_items.size() != 0) begin
               if (src_items[0].drain) send_now = token_records_due.size() == 0;
               else send_now = $urandom_range(99) >= send_idle_pct[src_items[0].phase];
            end
            if (send_now) begin
               next_item = src_items.pop_front();
               cur_phase = next_item.phase;
               req_valid <= 1'b1;
               req_src_byte <= next_item.ch;
               req_end_of_input <= next_item.eoi;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= $urandom_range(99) >= recv_idle_pct[cur_phase];
   end

   // record monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (token_records_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected record kind=%0d type=%0d byte=%02h",
                                    rsp_record_kind, rsp_token_type, rsp_value_byte));
         end else begin
            records_checked++;
            if (token_records_due[0].kind) begin
               token_ends++;
               if (token_records_due[0].tok == TOK_ERROR) error_ends++;
            end
            if (rsp_record_kind !== token_records_due[0].kind)
               flag_mismatch($sformatf("record %0d kind %0d, want %0d", records_checked,
                                       rsp_record_kind, token_records_due[0].kind));
            if (rsp_token_type !== token_records_due[0].tok)
               flag_mismatch($sformatf("record %0d type %0d, want %0d", records_checked,
                                       rsp_token_type, token_records_due[0].tok));
            if (rsp_value_byte !== token_records_due[0].value)
               flag_mismatch($sformatf("record %0d byte %02h, want %02h", records_checked,
                                       rsp_value_byte, token_records_due[0].value));
            if (rsp_last_in_run !== token_records_due[0].last)
               flag_mismatch($sformatf("record %0d last %0d, want %0d", records_checked,
                                       rsp_last_in_run, token_records_due[0].last));
            void'(token_records_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      // keyword, number, double bar, escaped char, escaped string, missing apostrophe
      push_text("while(3.5||'\\n'\"\\tx\"'ab");
      push_byte(8'hFF, 1'b0);
      push_byte(8'h41, 1'b1);
      push_byte(CH_QUOTE, 1'b0);
      push_byte(8'h00, 1'b0);
      for (int p = 0; p < 3; p++) begin
         gen_phase = p;
         gen_hold = 1;
         while (src_items.size() < (p + 1) * PHASE_ITEMS + 27) add_random_token();
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (src_items.size() != 0 || req_valid || token_records_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (token_records_due.size() != 0)
         flag_mismatch($sformatf("%0d records never arrived", token_records_due.size()));
      $display("lexed %0d source bytes into %0d records: %0d token ends, %0d of them errors",
               bytes_lexed, records_checked, token_ends, error_ends);
      $display("stall mixes sender/receiver 36/60, 60/36 and none, draining at each switch");
      if (mismatches == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
design/stt_pkg.sv
design/source_text_tokenizer.sv
verif/source_text_tokenizer_test.sv
